[hdl/mexp_pkg.sv]
// Shared types, widths and the microcode store for the modular exponentiation block.
// Used by mexp_mulmod and modular_exponentiation; depends on nothing.
package mexp_pkg;

    localparam int DW    = 16;
    localparam int CNT_W = $clog2(DW);
    localparam int PC_W  = 3;

    localparam logic [DW-1:0] MODULUS_RST  = DW'(221);
    localparam logic [DW-1:0] EXPONENT_RST = DW'(5);

    // register word addresses (paddr[2])
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    // microprogram step addresses
    localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [PC_W-1:0] STEP_SQ    = 3'd2;
    localparam logic [PC_W-1:0] STEP_TEST  = 3'd3;
    localparam logic [PC_W-1:0] STEP_ACC   = 3'd4;
    localparam logic [PC_W-1:0] STEP_SHIFT = 3'd5;
    localparam logic [PC_W-1:0] STEP_DONE  = 3'd6;
    localparam logic [PC_W-1:0] STEP_ZERO  = 3'd7;

    // branch conditions; when the condition holds the step jumps to its target
    // and performs no action, otherwise it acts and goes to its next step
    typedef enum logic [2:0] {
        CND_NEVER   = 3'd0,
        CND_NOSTART = 3'd1,
        CND_MULBUSY = 3'd2,
        CND_NSMALL  = 3'd3,
        CND_E0CLR   = 3'd4,
        CND_ELAST   = 3'd5
    } cond_t;

    typedef enum logic [1:0] {
        OPS_ONE_BASE = 2'd0,
        OPS_ACC_SQ   = 2'd1,
        OPS_SQ_SQ    = 2'd2
    } opsel_t;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_LOAD = 3'd1,
        WR_SQ   = 3'd2,
        WR_ACC  = 3'd3,
        WR_ZERO = 3'd4
    } wrsel_t;

    typedef struct packed {
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic [PC_W-1:0]  next;
        logic             issue;
        opsel_t           opsel;
        wrsel_t           wr;
        logic             shift_e;
        logic             strobe;
    } cw_t;

    function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
        cw_t cw;
        begin
            cw.cond    = CND_NEVER;
            cw.target  = STEP_IDLE;
            cw.next    = STEP_IDLE;
            cw.issue   = 1'b0;
            cw.opsel   = OPS_ONE_BASE;
            cw.wr      = WR_NONE;
            cw.shift_e = 1'b0;
            cw.strobe  = 1'b0;
            case (pc)
                STEP_IDLE:
                begin
                    cw.cond   = CND_NOSTART;
                    cw.target = STEP_IDLE;
                    cw.next   = STEP_CHECK;
                    cw.wr     = WR_LOAD;
                end
                STEP_CHECK:
                begin
                    cw.cond   = CND_NSMALL;
                    cw.target = STEP_ZERO;
                    cw.next   = STEP_SQ;
                    cw.issue  = 1'b1;
                    cw.opsel  = OPS_ONE_BASE;
                end
                STEP_SQ:
                begin
                    cw.cond   = CND_MULBUSY;
                    cw.target = STEP_SQ;
                    cw.next   = STEP_TEST;
                    cw.wr     = WR_SQ;
                end
                STEP_TEST:
                begin
                    cw.cond   = CND_E0CLR;
                    cw.target = STEP_SHIFT;
                    cw.next   = STEP_ACC;
                    cw.issue  = 1'b1;
                    cw.opsel  = OPS_ACC_SQ;
                end
                STEP_ACC:
                begin
                    cw.cond   = CND_MULBUSY;
                    cw.target = STEP_ACC;
                    cw.next   = STEP_SHIFT;
                    cw.wr     = WR_ACC;
                end
                STEP_SHIFT:
                begin
                    cw.cond    = CND_ELAST;
                    cw.target  = STEP_DONE;
                    cw.next    = STEP_SQ;
                    cw.issue   = 1'b1;
                    cw.opsel   = OPS_SQ_SQ;
                    cw.shift_e = 1'b1;
                end
                STEP_DONE:
                begin
                    cw.next   = STEP_IDLE;
                    cw.strobe = 1'b1;
                end
                STEP_ZERO:
                begin
                    cw.next = STEP_DONE;
                    cw.wr   = WR_ZERO;
                end
                default:
                begin
                    cw.next = STEP_IDLE;
                end
            endcase
            return cw;
        end
    endfunction

endpackage

[hdl/modular_exponentiation.sv]
// Modular exponentiation: base_value ^ exponent mod modulus, square-and-multiply.
// A modulus below 2 gives a zero result; otherwise the run time grows with the number
// of significant bits and of ones in the exponent.
// Each modular multiply runs in the bit-serial multiplier, which sets the rate.
// One item at a time: busy stays high from the accepting edge to the done strobe.
// rst_n clears the sequencer and loads modulus 221 and exponent 5.
module modular_exponentiation
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic [mexp_pkg::DW-1:0]  base_value,
    output logic                     done,
    output logic [mexp_pkg::DW-1:0]  power_result
);

    logic [mexp_pkg::DW-1:0]    modulus_reg;
    logic [mexp_pkg::DW-1:0]    exponent_reg;
    logic [mexp_pkg::PC_W-1:0]  pc_reg;
    logic [mexp_pkg::PC_W-1:0]  pc_next;
    logic [mexp_pkg::DW-1:0]    base_reg;
    logic [mexp_pkg::DW-1:0]    base_next;
    logic [mexp_pkg::DW-1:0]    e_reg;
    logic [mexp_pkg::DW-1:0]    e_next;
    logic [mexp_pkg::DW-1:0]    acc_reg;
    logic [mexp_pkg::DW-1:0]    acc_next;
    logic [mexp_pkg::DW-1:0]    sq_reg;
    logic [mexp_pkg::DW-1:0]    sq_next;

    mexp_pkg::cw_t              cw;
    logic                       take;
    logic                       act;
    logic                       cfg_wr;
    logic                       mul_start;
    logic                       mul_done;
    logic [mexp_pkg::DW-1:0]    mul_a;
    logic [mexp_pkg::DW-1:0]    mul_b;
    logic [mexp_pkg::DW-1:0]    mul_p;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::MODULUS_RST;
            exponent_reg <= mexp_pkg::EXPONENT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == mexp_pkg::REG_MODULUS)
            begin
                modulus_reg <= pwdata[mexp_pkg::DW-1:0];
            end
            else
            begin
                exponent_reg <= pwdata[mexp_pkg::DW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == mexp_pkg::REG_EXPONENT) ? 32'(exponent_reg)
                                                         : 32'(modulus_reg);

    // sequencer
    always_comb
    begin
        cw = mexp_pkg::ucode_rom(pc_reg);
        case (cw.cond)
            mexp_pkg::CND_NEVER:   take = 1'b0;
            mexp_pkg::CND_NOSTART: take = !start;
            mexp_pkg::CND_MULBUSY: take = !mul_done;
            mexp_pkg::CND_NSMALL:  take = (modulus_reg[mexp_pkg::DW-1:1] == '0);
            mexp_pkg::CND_E0CLR:   take = !e_reg[0];
            mexp_pkg::CND_ELAST:   take = (e_reg[mexp_pkg::DW-1:1] == '0);
            default:               take = 1'b0;
        endcase
        act       = !take;
        pc_next   = take ? cw.target : cw.next;
        mul_start = act & cw.issue;

        case (cw.opsel)
            mexp_pkg::OPS_ONE_BASE:
            begin
                mul_a = mexp_pkg::DW'(1);
                mul_b = base_reg;
            end
            mexp_pkg::OPS_ACC_SQ:
            begin
                mul_a = acc_reg;
                mul_b = sq_reg;
            end
            mexp_pkg::OPS_SQ_SQ:
            begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase

        base_next = base_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        if (act)
        begin
            case (cw.wr)
                mexp_pkg::WR_NONE:
                begin
                    acc_next = acc_reg;
                end
                mexp_pkg::WR_LOAD:
                begin
                    // exponents 0 and 1 both run as 1
                    base_next = base_value;
                    e_next    = exponent_reg | mexp_pkg::DW'(exponent_reg == '0);
                    acc_next  = mexp_pkg::DW'(1);
                end
                mexp_pkg::WR_SQ:   sq_next  = mul_p;
                mexp_pkg::WR_ACC:  acc_next = mul_p;
                mexp_pkg::WR_ZERO: acc_next = '0;
                default:           acc_next = acc_reg;
            endcase
            if (cw.shift_e)
            begin
                e_next = {1'b0, e_reg[mexp_pkg::DW-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mexp_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
    end

    mexp_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (modulus_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    assign busy         = (pc_reg != mexp_pkg::STEP_IDLE);
    assign done         = cw.strobe;
    assign power_result = acc_reg;

endmodule

[hdl/mexp_mulmod.sv]
// Bit-serial modular multiplier: product = a * b mod n, one bit of b per cycle.
// Requires a < n. Uses mexp_pkg for widths.
module mexp_mulmod
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mexp_pkg::DW-1:0]  op_a,
    input  logic [mexp_pkg::DW-1:0]  op_b,
    input  logic [mexp_pkg::DW-1:0]  modulus,
    output logic                     done,
    output logic [mexp_pkg::DW-1:0]  product
);

    logic                          run_reg;
    logic                          run_next;
    logic                          done_reg;
    logic                          done_next;
    logic [mexp_pkg::CNT_W-1:0]    cnt_reg;
    logic [mexp_pkg::CNT_W-1:0]    cnt_next;
    logic [mexp_pkg::DW-1:0]       a_reg;
    logic [mexp_pkg::DW-1:0]       a_next;
    logic [mexp_pkg::DW-1:0]       b_reg;
    logic [mexp_pkg::DW-1:0]       b_next;
    logic [mexp_pkg::DW-1:0]       r_reg;
    logic [mexp_pkg::DW-1:0]       r_next;

    logic [mexp_pkg::DW:0]         dbl;
    logic [mexp_pkg::DW-1:0]       dbl_red;
    logic [mexp_pkg::DW:0]         sum;
    logic [mexp_pkg::DW-1:0]       sum_red;
    logic                          last;

    always_comb
    begin
        // r = 2r mod n, then r = r + a mod n when the current bit of b is set
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? mexp_pkg::DW'(dbl - {1'b0, modulus})
                                           : mexp_pkg::DW'(dbl);
        sum     = {1'b0, dbl_red} + (b_reg[mexp_pkg::DW-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, modulus}) ? mexp_pkg::DW'(sum - {1'b0, modulus})
                                           : mexp_pkg::DW'(sum);
        last    = (cnt_reg == mexp_pkg::CNT_W'(mexp_pkg::DW - 1));

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            a_next   = op_a;
            b_next   = op_b;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            r_next   = sum_red;
            b_next   = {b_reg[mexp_pkg::DW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule
